// ===== src/wva_pkg.sv =====
// ----------------------------------------------------------------------------
// wva_pkg
// Shared widths, sequencing constants and the lane control bundle for the
// windowed vector average core.
// ----------------------------------------------------------------------------
`default_nettype none

package wva_pkg;

  // Sample and result width, signed Q8.16
  localparam int SAMPLE_W = 24;
  // Running sum width, holds 1023 * 2^23 with sign
  localparam int SUM_W = 34;
  // Divider retires two quotient bits per cycle
  localparam int DIV_BITS_PER_STEP = 2;
  localparam int DIV_STEPS = SUM_W / DIV_BITS_PER_STEP;
  localparam int STEP_W = $clog2(DIV_STEPS + 1);

  // Control bundle broadcast from the sequencer to every lane
  typedef struct packed {
    logic load;   // capture the incoming sample
    logic rd;     // read the ring entry at the write position
    logic upd;    // update the sum, write the ring, start the divider
    logic full;   // ring full: oldest entry leaves the sum
    logic step;   // advance the divider by one step
  } lane_ctrl_t;

endpackage

`default_nettype wire

// ===== src/wva_ifs.sv =====
// ----------------------------------------------------------------------------
// wva_sample_if / wva_mean_if
// Valid/ready channels for incoming samples and outgoing means.
// ----------------------------------------------------------------------------
`default_nettype none

interface wva_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [wva_pkg::SAMPLE_W-1:0] sample_x;
  logic signed [wva_pkg::SAMPLE_W-1:0] sample_y;
  logic signed [wva_pkg::SAMPLE_W-1:0] sample_z;

  modport source (output valid, sample_x, sample_y, sample_z, input ready);
  modport sink   (input valid, sample_x, sample_y, sample_z, output ready);
endinterface

interface wva_mean_if;
  logic                                valid;
  logic                                ready;
  logic signed [wva_pkg::SAMPLE_W-1:0] mean_x;
  logic signed [wva_pkg::SAMPLE_W-1:0] mean_y;
  logic signed [wva_pkg::SAMPLE_W-1:0] mean_z;

  modport source (output valid, mean_x, mean_y, mean_z, input ready);
  modport sink   (input valid, mean_x, mean_y, mean_z, output ready);
endinterface

`default_nettype wire

// ===== src/wva_lane.sv =====
// ----------------------------------------------------------------------------
// wva_lane
// One axis: ring memory of the window, running sum, and a radix-4 serial
// divider that forms the truncated mean.
// ----------------------------------------------------------------------------
`default_nettype none

module wva_lane #(
  parameter int  WINDOW = 600,
  localparam int ADDR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1,
  localparam int CNT_W  = $clog2(WINDOW + 1)
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire wva_pkg::lane_ctrl_t            ctrl,
  input  wire [ADDR_W-1:0]                    addr,
  input  wire [CNT_W-1:0]                     divisor,
  input  wire signed [wva_pkg::SAMPLE_W-1:0]  sample,
  output logic signed [wva_pkg::SAMPLE_W-1:0] mean
);

  localparam int SW     = wva_pkg::SAMPLE_W;
  localparam int UW     = wva_pkg::SUM_W;

  logic [SW-1:0]        ring [WINDOW];
  logic [SW-1:0]        old;
  logic signed [SW-1:0] sample_q;
  logic signed [UW-1:0] sum;
  logic signed [UW-1:0] sum_next;
  logic [UW-1:0]        mag_next;
  logic [UW-1:0]        dvd;
  logic [UW-1:0]        dvd_next;
  logic [CNT_W-1:0]     rem;
  logic [CNT_W-1:0]     rem_next;
  logic                 neg;

  // Ring memory: one write and one registered read
  always_ff @(posedge clk) begin
    if (ctrl.upd) begin
      ring[addr] <= sample_q;
    end
    if (ctrl.rd) begin
      old <= ring[addr];
    end
  end

  // Drop the oldest entry when full, add the new sample
  always_comb begin
    sum_next = sum + UW'(sample_q);
    if (ctrl.full) begin
      sum_next = sum_next - UW'($signed(old));
    end
    mag_next = sum_next[UW-1] ? UW'(-sum_next) : UW'(sum_next);
  end

  // Two restoring divide steps per cycle
  always_comb begin
    logic [CNT_W:0] rs;
    rs       = '0;
    rem_next = rem;
    dvd_next = dvd;
    for (int i = 0; i < wva_pkg::DIV_BITS_PER_STEP; i++) begin
      rs       = {rem_next, dvd_next[UW-1]};
      dvd_next = {dvd_next[UW-2:0], 1'b0};
      if (rs >= {1'b0, divisor}) begin
        rem_next    = CNT_W'(rs - {1'b0, divisor});
        dvd_next[0] = 1'b1;
      end else begin
        rem_next = rs[CNT_W-1:0];
      end
    end
  end

  // Running sum starts from zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (ctrl.upd) begin
      sum <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      sample_q <= sample;
    end
    if (ctrl.upd) begin
      neg <= sum_next[UW-1];
      dvd <= mag_next;
      rem <= '0;
    end else if (ctrl.step) begin
      dvd <= dvd_next;
      rem <= rem_next;
    end
  end

  // Restore the sign of the truncated quotient
  assign mean = neg ? SW'(-dvd[SW-1:0]) : $signed(dvd[SW-1:0]);

endmodule

`default_nettype wire

// ===== src/windowed_vector_average_core.sv =====
// ----------------------------------------------------------------------------
// windowed_vector_average_core
// Boxcar moving average of 3-D samples over the last WINDOW samples, or over
// all samples so far while the window fills.
// Each sample transfer is followed by a ring read, a sum update, 17 radix-4
//   divider steps and an output load, which waits while the output is stalled.
// A new sample is accepted only after the previous mean has been loaded.
// Reset: rst clears the sums, write position, fill count and output valid;
//   the ring memory is not cleared and an entry is used only after it was written.
`default_nettype none

module windowed_vector_average_core #(
  parameter int WINDOW = 600
) (
  input wire          clk,
  input wire          rst,
  wva_sample_if.sink  sample_in,
  wva_mean_if.source  mean_out
);

  localparam int ADDR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SW     = wva_pkg::SAMPLE_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_UPDATE,
    S_DIV,
    S_OUT
  } state_t;

  state_t                  state;
  logic [ADDR_W-1:0]       write_pos;
  logic [CNT_W-1:0]        fill_count;
  logic [wva_pkg::STEP_W-1:0] step_cnt;
  logic                    full;
  logic [CNT_W-1:0]        divisor;
  wva_pkg::lane_ctrl_t     ctrl;
  logic signed [SW-1:0]    lane_mean [3];
  logic signed [SW-1:0]    lane_sample [3];
  logic                    out_free;

  // Divide by the fill count, already advanced and saturated while dividing
  assign full     = (fill_count == CNT_W'(WINDOW));
  assign divisor  = fill_count;
  assign out_free = !mean_out.valid || mean_out.ready;

  assign sample_in.ready = (state == S_IDLE);

  // Lane control from the sequencer state
  always_comb begin
    ctrl      = '0;
    ctrl.load = sample_in.valid && sample_in.ready;
    ctrl.rd   = (state == S_READ);
    ctrl.upd  = (state == S_UPDATE);
    ctrl.full = full;
    ctrl.step = (state == S_DIV);
  end

  assign lane_sample[0] = sample_in.sample_x;
  assign lane_sample[1] = sample_in.sample_y;
  assign lane_sample[2] = sample_in.sample_z;

  // One lane per axis
  for (genvar g = 0; g < 3; g++) begin : g_lane
    wva_lane #(
      .WINDOW (WINDOW)
    ) u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .addr    (write_pos),
      .divisor (divisor),
      .sample  (lane_sample[g]),
      .mean    (lane_mean[g])
    );
  end

  // Sequencer, ring pointers and merged output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      write_pos      <= '0;
      fill_count     <= '0;
      step_cnt       <= '0;
      mean_out.valid <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) begin
        mean_out.valid <= 1'b1;
      end else if (mean_out.valid && mean_out.ready) begin
        mean_out.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (sample_in.valid) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          if (write_pos == ADDR_W'(WINDOW - 1)) begin
            write_pos <= '0;
          end else begin
            write_pos <= write_pos + 1'b1;
          end
          if (!full) begin
            fill_count <= fill_count + 1'b1;
          end
          step_cnt <= '0;
          state    <= S_DIV;
        end
        S_DIV: begin
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == wva_pkg::STEP_W'(wva_pkg::DIV_STEPS - 1)) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Merge lane results into the output payload
  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      mean_out.mean_x <= lane_mean[0];
      mean_out.mean_y <= lane_mean[1];
      mean_out.mean_z <= lane_mean[2];
    end
  end

endmodule

`default_nettype wire

// ===== src/wva_checker.sv =====
// ----------------------------------------------------------------------------
// wva_checker
// Port-level checks on the windowed vector average core, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module wva_checker (
  input wire                       clk,
  input wire                       rst,
  input wire                       in_valid,
  input wire                       in_ready,
  input wire                       out_valid,
  input wire                       out_ready,
  input wire [wva_pkg::SAMPLE_W-1:0] mean_x,
  input wire [wva_pkg::SAMPLE_W-1:0] mean_y,
  input wire [wva_pkg::SAMPLE_W-1:0] mean_z
);

  // Reset leaves the core idle with nothing to deliver
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> (!out_valid && in_ready))
    else $error("core not idle after reset");

  // Only one sample in flight: no new transfer right after one
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("sample accepted while another is in flight");

  // A mean needs the full update and divide, never appears at once
  a_no_early_mean: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> ##1 !$rose(out_valid) ##1 !$rose(out_valid))
    else $error("mean appeared too soon after a sample");

  // Stalled output holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(mean_x) && $stable(mean_y) && $stable(mean_z)))
    else $error("stalled mean changed or dropped");

endmodule

bind windowed_vector_average_core wva_checker u_wva_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (sample_in.valid),
  .in_ready  (sample_in.ready),
  .out_valid (mean_out.valid),
  .out_ready (mean_out.ready),
  .mean_x    (mean_out.mean_x),
  .mean_y    (mean_out.mean_y),
  .mean_z    (mean_out.mean_z)
);

`default_nettype wire

// ===== sim/wva_mean_checker.sv =====
// ----------------------------------------------------------------------------
// wva_mean_checker
// Watches the sample and mean channels of the windowed vector average core.
// Keeps its own window of samples and running sums per axis, works out the
// truncated mean for every sample transfer, and compares each mean transfer
// against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module wva_mean_checker #(
  parameter int WINDOW = 600
) (
  input  wire   clk,
  input  wire   rst,
  wva_sample_if sample_ch,
  wva_mean_if   mean_ch,
  output int    fail_count,
  output int    pending_means
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [wva_pkg::SAMPLE_W-1:0] coord_t;
  typedef logic signed [wva_pkg::SUM_W-1:0]    total_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;

  // Window contents and running sums, mirrored from the sample stream
  coord_t      hist_x [WINDOW];
  coord_t      hist_y [WINDOW];
  coord_t      hist_z [WINDOW];
  total_t      total_x;
  total_t      total_y;
  total_t      total_z;
  int unsigned slot;
  int unsigned stored;
  int          mismatches;
  vec_t        expected_means [$];

  // Divide and truncate toward zero, keep the low 24 bits
  function automatic coord_t trunc_mean(input total_t total, input int unsigned count);
    longint quotient;
    quotient = longint'(total) / longint'(count);
    return quotient[wva_pkg::SAMPLE_W-1:0];
  endfunction

  // Retire the oldest sample once the window is full, then add the new one
  task automatic advance_window(input vec_t s);
    vec_t m;
    if (stored == WINDOW) begin
      total_x = total_x - hist_x[slot];
      total_y = total_y - hist_y[slot];
      total_z = total_z - hist_z[slot];
    end
    hist_x[slot] = s.x;
    hist_y[slot] = s.y;
    hist_z[slot] = s.z;
    total_x = total_x + s.x;
    total_y = total_y + s.y;
    total_z = total_z + s.z;
    slot = (slot == WINDOW - 1) ? 0 : slot + 1;
    if (stored < WINDOW) stored++;
    m.x = trunc_mean(total_x, stored);
    m.y = trunc_mean(total_y, stored);
    m.z = trunc_mean(total_z, stored);
    expected_means.insert(expected_means.size(), m);
  endtask

  task automatic compare_axis(input string name, input coord_t want, input coord_t got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_mean(input vec_t got);
    vec_t want;
    if (expected_means.size() == 0) begin
      $error("mean transfer with nothing outstanding: x=%0d y=%0d z=%0d",
             got.x, got.y, got.z);
      mismatches++;
    end else begin
      want = expected_means.pop_front();
      compare_axis("mean_x", want.x, got.x);
      compare_axis("mean_y", want.y, got.y);
      compare_axis("mean_z", want.z, got.z);
    end
  endtask

  initial mismatches = 0;

  // Score the output first, then account for the sample taken at this edge
  always @(posedge clk) begin
    if (rst) begin
      total_x = '0;
      total_y = '0;
      total_z = '0;
      slot    = 0;
      stored  = 0;
      expected_means.delete();
    end else begin
      if (mean_ch.valid && mean_ch.ready) begin
        check_mean('{mean_ch.mean_x, mean_ch.mean_y, mean_ch.mean_z});
      end
      if (sample_ch.valid && sample_ch.ready) begin
        advance_window('{sample_ch.sample_x, sample_ch.sample_y, sample_ch.sample_z});
      end
    end
    pending_means <= expected_means.size();
    fail_count    <= mismatches;
  end

endmodule

`default_nettype wire

// ===== sim/tb_windowed_vector_average_core.sv =====
// ----------------------------------------------------------------------------
// tb_windowed_vector_average_core
// Drives samples into the windowed vector average core and drains its means.
// A directed set covers the field extremes and truncation toward zero, then
// a full window of extreme values and random bursts with per-axis value
// styles take the sample count past two window fills. Both channels idle at
// random, the receiver holds off once for a long stretch, and the verdict
// comes from the attached checker.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_windowed_vector_average_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW          = 600;
  localparam int RANDOM_ITEMS    = 1200;
  localparam int HOLD_OFF_AT     = 100;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 40;
  localparam int CYCLE_LIMIT     = 400000;

  typedef logic signed [wva_pkg::SAMPLE_W-1:0] coord_t;

  localparam coord_t S_MAX = 24'sh7FFFFF;
  localparam coord_t S_MIN = 24'sh800000;
  localparam coord_t ALT_A = 24'sh555555;
  localparam coord_t ALT_B = 24'shAAAAAA;

  typedef enum int {
    KIND_RANDOM,
    KIND_HIGH,
    KIND_LOW,
    KIND_NEAR_ZERO,
    KIND_ONE_HOT
  } value_kind_e;

  logic        clk;
  logic        rst;
  int          fail_count;
  int          pending_means;
  int          cycle_count;
  bit          tight_phase;
  int unsigned means_taken;

  wva_sample_if sample_ch ();
  wva_mean_if   mean_ch ();

  windowed_vector_average_core #(
    .WINDOW (WINDOW)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .sample_in (sample_ch),
    .mean_out  (mean_ch)
  );

  wva_mean_checker #(
    .WINDOW (WINDOW)
  ) mean_check (
    .clk           (clk),
    .rst           (rst),
    .sample_ch     (sample_ch),
    .mean_ch       (mean_ch),
    .fail_count    (fail_count),
    .pending_means (pending_means)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle cycles before the next transfer; none during a tight stretch
  function automatic int draw_gap();
    return tight_phase ? 0 : int'($urandom_range(0, 10));
  endfunction

  function automatic coord_t pick_value(input value_kind_e kind);
    coord_t v;
    case (kind)
      KIND_HIGH:      v = S_MAX - coord_t'($urandom_range(0, 15));
      KIND_LOW:       v = S_MIN + coord_t'($urandom_range(0, 15));
      KIND_NEAR_ZERO: v = coord_t'(int'($urandom_range(0, 32)) - 16);
      KIND_ONE_HOT: begin
        v = coord_t'(1) << $urandom_range(0, wva_pkg::SAMPLE_W - 1);
        if ($urandom_range(0, 1) == 1) v = ~v;
      end
      default:        v = coord_t'($urandom);
    endcase
    return v;
  endfunction

  function automatic value_kind_e pick_kind();
    return value_kind_e'($urandom_range(0, 4));
  endfunction

  // Offer one sample and hold it until it transfers
  task automatic send_sample(input coord_t x, input coord_t y, input coord_t z);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid    <= 1'b1;
    sample_ch.sample_x <= x;
    sample_ch.sample_y <= y;
    sample_ch.sample_z <= z;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
  endtask

  // Drop valid and hold until every outstanding mean has come back
  task automatic drain_means();
    sample_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_means != 0);
  endtask

  // Sink side: random stalls, one long hold-off while the source keeps offering samples
  initial begin
    int stall;
    mean_ch.ready <= 1'b0;
    means_taken = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = draw_gap();
      if (means_taken == HOLD_OFF_AT) stall = HOLD_OFF_CYCLES;
      if (stall > 0) begin
        mean_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      mean_ch.ready <= 1'b1;
      @(posedge clk);
      while (!mean_ch.valid) @(posedge clk);
      means_taken++;
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Source side and verdict
  initial begin
    int          sent;
    int          burst;
    value_kind_e kind_x;
    value_kind_e kind_y;
    value_kind_e kind_z;

    rst                <= 1'b1;
    sample_ch.valid    <= 1'b0;
    sample_ch.sample_x <= '0;
    sample_ch.sample_y <= '0;
    sample_ch.sample_z <= '0;
    tight_phase = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Extremes, sign mixes and means that must truncate toward zero
    send_sample(S_MAX, S_MAX, S_MAX);
    send_sample(S_MIN, S_MIN, S_MIN);
    send_sample('0, '0, '0);
    send_sample(coord_t'(-1), coord_t'(-1), coord_t'(-1));
    send_sample(coord_t'(-1), coord_t'(1), '0);
    send_sample(S_MIN, S_MAX, coord_t'(-1));
    send_sample(S_MAX, S_MIN, coord_t'(1));
    send_sample(ALT_A, ALT_B, ALT_A);
    send_sample(ALT_B, ALT_A, ALT_B);
    send_sample(coord_t'(1), coord_t'(-1), coord_t'(2));
    send_sample(coord_t'(-3), coord_t'(3), coord_t'(-2));
    send_sample(S_MIN, S_MIN, S_MIN);
    send_sample(S_MIN, S_MIN, S_MIN);
    send_sample(S_MIN, S_MAX, S_MIN);
    send_sample(S_MAX, S_MAX, S_MAX);
    send_sample(S_MAX, S_MIN, S_MAX);
    drain_means();

    // Fill and overrun the window with extremes to push the sums to their limits
    sent = 0;
    tight_phase = 1'b1;
    repeat (WINDOW + 24) begin
      send_sample(S_MAX, S_MIN, sent[0] ? S_MIN : S_MAX);
      sent++;
      if (sent % 50 == 0) tight_phase = ($urandom_range(0, 1) == 0);
    end
    tight_phase = 1'b0;
    drain_means();

    // Random bursts, each axis with its own value style
    while (sent < RANDOM_ITEMS) begin
      burst       = $urandom_range(1, 120);
      kind_x      = pick_kind();
      kind_y      = pick_kind();
      kind_z      = pick_kind();
      tight_phase = ($urandom_range(0, 3) == 0);
      repeat (burst) begin
        send_sample(pick_value(kind_x), pick_value(kind_y), pick_value(kind_z));
        sent++;
      end
    end
    tight_phase = 1'b0;

    drain_means();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_means == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
src/wva_pkg.sv
src/wva_ifs.sv
src/wva_lane.sv
src/windowed_vector_average_core.sv
src/wva_checker.sv
sim/wva_mean_checker.sv
sim/tb_windowed_vector_average_core.sv
